// ===== rtl/hpe_pkg.sv =====
// Package for the Horner polynomial evaluator: item, result and chain link types.
// No dependencies; used by hpe_cell and horner_polynomial_evaluator.
`default_nettype none

package hpe_pkg;

	localparam int COEF_INDEX_W = 3;
	localparam int MAX_INDEX    = (1 << COEF_INDEX_W) - 1;
	localparam int Q_SHIFT      = 16;

	typedef enum logic [0:0] {
		FUNC_LOAD = 1'b0,
		FUNC_EVAL = 1'b1
	} func_t;

	typedef struct packed {
		func_t                   func;
		logic [COEF_INDEX_W-1:0] coef_index;
		logic signed [31:0]      coef_value;
		logic signed [31:0]      x_value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] poly_value;
		logic               overflow;
	} result_t;

	// What one cell hands to the next: the item plus the running Horner sum.
	typedef struct packed {
		logic                    valid;
		func_t                   func;
		logic [COEF_INDEX_W-1:0] coef_index;
		logic signed [31:0]      coef_value;
		logic signed [31:0]      x_value;
		logic signed [31:0]      acc;
		logic                    overflow;
	} link_t;

endpackage

`default_nettype wire

// ===== rtl/horner_polynomial_evaluator.sv =====
// Horner polynomial evaluator, top level: input chain head, degree register,
// row of hpe_cell and result port. Depends on hpe_pkg and hpe_cell.
`default_nettype none

// Evaluates p(x) by Horner's rule in signed Q16.16, one item per cycle when the
// result side keeps up. Each coefficient lives in its own cell of a chain of
// min(MAX_DEGREE, 7) + 1 cells; an item walks the chain from the top coefficient
// down, two register stages per cell (multiply, then add and saturate), and its
// result leaves the bottom cell, the one of coefficient 0. Load items
// travel the same chain and write their cell on the way, so loads and
// evaluations keep their order; they give no result. A stalled result freezes
// the whole chain, and the input is stalled with it. The degree register is
// taken at once; write it only while the chain is empty.
module horner_polynomial_evaluator
	import hpe_pkg::*;
#(
	parameter int MAX_DEGREE = 7
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    item_valid,
	output logic                         item_stall,
	input  wire item_t                   item,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output result_t                      result,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [COEF_INDEX_W-1:0] cfg_data
);

	localparam int DEPTH = ((MAX_DEGREE < MAX_INDEX) ? MAX_DEGREE : MAX_INDEX) + 1;
	localparam logic [COEF_INDEX_W-1:0] TOP_INDEX = COEF_INDEX_W'(DEPTH - 1);

	logic [COEF_INDEX_W-1:0] degree_q;
	logic [COEF_INDEX_W-1:0] degree_used;
	logic                    advance;
	link_t                   chain_head;
	link_t                   chain [DEPTH+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
		end else if (cfg_valid) begin
			degree_q <= cfg_data;
		end
	end

	assign degree_used = (degree_q > TOP_INDEX) ? TOP_INDEX : degree_q;

	assign advance    = !(result_valid && result_stall);
	assign item_stall = !advance;

	always_comb begin
		chain_head            = '0;
		chain_head.valid      = item_valid && advance;
		chain_head.func       = item.func;
		chain_head.coef_index = item.coef_index;
		chain_head.coef_value = item.coef_value;
		chain_head.x_value    = item.x_value;
	end

	assign chain[DEPTH] = chain_head;

	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		hpe_cell #(
			.INDEX(j)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.degree   (degree_used),
			.link_in  (chain[j+1]),
			.link_out (chain[j])
		);
	end

	assign result_valid      = chain[0].valid && chain[0].func == FUNC_EVAL;
	assign result.poly_value = chain[0].acc;
	assign result.overflow   = chain[0].overflow;

endmodule

`default_nettype wire

// ===== rtl/hpe_cell.sv =====
// One Horner cell: holds one coefficient, multiplies the running sum by x, then
// adds its coefficient with saturation. Two register stages. Depends on hpe_pkg.
`default_nettype none

module hpe_cell
	import hpe_pkg::*;
#(
	parameter int INDEX = 0
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    advance,
	input  wire logic [COEF_INDEX_W-1:0] degree,
	input  wire link_t                   link_in,
	output link_t                        link_out
);

	link_t              link_s1;
	link_t              link_s2;
	link_t              link_next;
	logic signed [63:0] product_s1;
	logic signed [31:0] coef_q;
	logic signed [63:0] shifted;
	logic signed [48:0] sum;
	logic signed [31:0] sum_sat;
	logic               sat_flag;
	logic               coef_load;

	localparam logic [COEF_INDEX_W-1:0] MY_INDEX = COEF_INDEX_W'(INDEX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_s1 <= '0;
		end else if (advance) begin
			link_s1 <= link_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			product_s1 <= $signed(link_in.acc) * $signed(link_in.x_value);
		end
	end

	// floor(p * x / 2^16) plus coefficient, saturated to 32 bits
	always_comb begin
		shifted = product_s1 >>> Q_SHIFT;
		sum     = $signed({shifted[47], shifted[47:0]}) + $signed({{17{coef_q[31]}}, coef_q});
		sat_flag = (sum[48:31] != {18{1'b0}}) && (sum[48:31] != {18{1'b1}});
		if (!sat_flag) begin
			sum_sat = sum[31:0];
		end else if (sum[48]) begin
			sum_sat = 32'sh8000_0000;
		end else begin
			sum_sat = 32'sh7fff_ffff;
		end
	end

	// Above the degree an item passes untouched; at the degree the sum starts.
	always_comb begin
		link_next = link_s1;
		if (link_s1.valid && link_s1.func == FUNC_EVAL) begin
			if (degree == MY_INDEX) begin
				link_next.acc      = coef_q;
				link_next.overflow = 1'b0;
			end else if (degree > MY_INDEX) begin
				link_next.acc      = sum_sat;
				link_next.overflow = link_s1.overflow | sat_flag;
			end
		end
	end

	assign coef_load = advance && link_s1.valid && link_s1.func == FUNC_LOAD
		&& link_s1.coef_index == MY_INDEX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= '0;
			link_s2 <= '0;
		end else begin
			if (coef_load) begin
				coef_q <= link_s1.coef_value;
			end
			if (advance) begin
				link_s2 <= link_next;
			end
		end
	end

	assign link_out = link_s2;

endmodule

`default_nettype wire
